FILE: design/aswp_pkg.sv
`default_nettype none

package aswp_pkg;

  localparam int DEPTH    = 64;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CNT_W    = 7;
  localparam int WORD_W   = 32;
  localparam int CAP_W    = 7;
  localparam int POS_W    = 7;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  typedef enum logic [1:0] {
    ACT_PUSH = 2'd0,
    ACT_POP  = 2'd1,
    ACT_PEEK = 2'd2,
    ACT_NOP  = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_BADPOS    = 2'd3
  } status_t;

  // where the top word of a result comes from
  typedef enum logic [1:0] {
    TOP_ZERO = 2'd0,
    TOP_WORD = 2'd1,
    TOP_RAM  = 2'd2
  } top_sel_t;

  typedef struct packed {
    status_t            status;
    logic               rd_from_ram;
    top_sel_t           top_sel;
    logic [WORD_W-1:0]  word;
    logic [WORD_W-1:0]  bottom;
    logic [CNT_W-1:0]   count;
  } s1_meta_t;

endpackage

`default_nettype wire

FILE: design/aswp_ram.sv
`default_nettype none

module aswp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       re,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr_b,
  output logic      [WIDTH-1:0]           rdata_a,
  output logic      [WIDTH-1:0]           rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

FILE: design/array_stack_with_peek_top.sv
`default_nettype none

// LIFO stack of 32-bit words with push, pop and peek-by-position. One request
// is taken every cycle while in_stall is low; its result passes through the
// two registered read ports of the stack RAM (read at the accepting edge)
// and then the output register before it shows up on the outputs. in_stall
// rises only when both stages hold results that the consumer has not taken.
// Every result carries the read word, a status code, the top and bottom words
// and the entry count after the request. cfg_wr_data sets the capacity
// (reset 64, clipped at 64); write it only while no request is in flight.
module array_stack_with_peek_top (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_wr_en,
  input  wire logic        [aswp_pkg::CAP_W-1:0]      cfg_wr_data,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic        [1:0]                      in_action,
  input  wire logic signed [aswp_pkg::WORD_W-1:0]     in_push_value,
  input  wire logic        [aswp_pkg::POS_W-1:0]      in_position,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed      [aswp_pkg::WORD_W-1:0]     out_read_value,
  output logic             [1:0]                      out_status,
  output logic signed      [aswp_pkg::WORD_W-1:0]     out_top_value,
  output logic signed      [aswp_pkg::WORD_W-1:0]     out_bottom_value,
  output logic             [aswp_pkg::CNT_W-1:0]      out_entry_count
);

  import aswp_pkg::*;

  logic [CAP_W-1:0]   cap_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [WORD_W-1:0]  bottom_r, bottom_nxt;

  logic               s1_valid_r, s1_valid_nxt;
  s1_meta_t           s1_meta_r, s1_meta_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]  out_read_r, out_read_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [WORD_W-1:0]  out_top_r, out_top_nxt;
  logic [WORD_W-1:0]  out_bottom_r, out_bottom_nxt;
  logic [CNT_W-1:0]   out_count_r, out_count_nxt;

  logic               in_accept;
  logic               out_free;
  logic               s1_adv;
  logic               push_ok;
  act_t               act;
  status_t            status;
  logic               rd_ram;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ADDR_W-1:0]  ram_raddr_a;
  logic [ADDR_W-1:0]  ram_raddr_b;
  logic [WORD_W-1:0]  ram_rdata_a;
  logic [WORD_W-1:0]  ram_rdata_b;
  logic [CNT_W-1:0]   peek_idx;
  logic [CNT_W-1:0]   pop_idx;
  logic [CNT_W-1:0]   top_idx;

  // handshake
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  // request decode against current state
  always_comb begin
    act       = act_t'(in_action);
    status    = ST_OK;
    push_ok   = 1'b0;
    rd_ram    = 1'b0;
    count_nxt = count_r;
    unique case (act)
      ACT_PUSH: begin
        if (count_r >= cap_r || count_r >= DEPTH_CNT) begin
          status = ST_OVERFLOW;
        end else begin
          push_ok   = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      ACT_POP: begin
        if (count_r == '0) begin
          status = ST_UNDERFLOW;
        end else begin
          rd_ram    = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      ACT_PEEK: begin
        if (in_position == '0 || in_position > count_r) begin
          status = ST_BADPOS;
        end else begin
          rd_ram = 1'b1;
        end
      end
      ACT_NOP: begin
      end
      default: begin
      end
    endcase
  end

  assign peek_idx    = count_r - in_position;
  assign pop_idx     = count_r - CNT_W'(1);
  assign top_idx     = count_nxt - CNT_W'(1);
  assign ram_raddr_a = (act == ACT_PEEK) ? peek_idx[ADDR_W-1:0] : pop_idx[ADDR_W-1:0];
  assign ram_raddr_b = top_idx[ADDR_W-1:0];
  assign ram_we      = in_accept && push_ok;
  assign ram_waddr   = count_r[ADDR_W-1:0];

  always_comb begin
    bottom_nxt = bottom_r;
    if (ram_we && count_r == '0) begin
      bottom_nxt = in_push_value;
    end
  end

  always_comb begin
    s1_meta_nxt             = s1_meta_r;
    s1_meta_nxt.status      = status;
    s1_meta_nxt.rd_from_ram = rd_ram;
    s1_meta_nxt.word        = in_push_value;
    s1_meta_nxt.count       = count_nxt;
    if (count_nxt == '0) begin
      s1_meta_nxt.top_sel = TOP_ZERO;
      s1_meta_nxt.bottom  = '0;
    end else begin
      // a fresh push sits on top; its RAM write lands at this same edge
      s1_meta_nxt.top_sel = push_ok ? TOP_WORD : TOP_RAM;
      s1_meta_nxt.bottom  = (push_ok && count_r == '0) ? in_push_value : bottom_r;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  aswp_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_stack_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (in_push_value),
    .re      (in_accept),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  // result assembly
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_read_nxt   = out_read_r;
    out_status_nxt = out_status_r;
    out_top_nxt    = out_top_r;
    out_bottom_nxt = out_bottom_r;
    out_count_nxt  = out_count_r;
    if (out_free) begin
      out_valid_nxt = s1_valid_r;
    end
    if (s1_adv) begin
      out_read_nxt   = s1_meta_r.rd_from_ram ? ram_rdata_a : '0;
      out_status_nxt = s1_meta_r.status;
      out_bottom_nxt = s1_meta_r.bottom;
      out_count_nxt  = s1_meta_r.count;
      unique case (s1_meta_r.top_sel)
        TOP_ZERO: out_top_nxt = '0;
        TOP_WORD: out_top_nxt = s1_meta_r.word;
        TOP_RAM:  out_top_nxt = ram_rdata_b;
        default:  out_top_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (in_accept) begin
        count_r <= count_nxt;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      bottom_r  <= bottom_nxt;
      s1_meta_r <= s1_meta_nxt;
    end
    out_read_r   <= out_read_nxt;
    out_status_r <= out_status_nxt;
    out_top_r    <= out_top_nxt;
    out_bottom_r <= out_bottom_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_read_value   = out_read_r;
  assign out_status       = out_status_r;
  assign out_top_value    = out_top_r;
  assign out_bottom_value = out_bottom_r;
  assign out_entry_count  = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_CNT)
    else $error("stack count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && push_ok |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("push did not grow the stack");

  a_ovf_no_top_word: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_meta_r.status == ST_OVERFLOW |-> s1_meta_r.top_sel != TOP_WORD)
    else $error("overflowed push shown as top");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_count_r == '0 |-> out_top_r == '0 && out_bottom_r == '0)
    else $error("empty stack with nonzero top or bottom");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("stall with empty read stage");

endmodule

`default_nettype wire
